[hdl/piezo_hit_detector_unit_defines.svh]
// assertion macros used by phd_merge
`ifndef PIEZO_HIT_DETECTOR_UNIT_DEFINES_SVH
`define PIEZO_HIT_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define PHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/phd_pkg.sv]
`default_nettype none

package phd_pkg;

    localparam int NUM_PADS_DEF    = 4;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int THRESH_BITS = 12;
    localparam int COEFF_BITS  = 17;
    localparam int Q_FRAC_BITS = 16;
    localparam int FORCE_BITS  = 16;

    localparam logic [COEFF_BITS-1:0]  Q_ONE           = 17'h10000;
    localparam logic [FORCE_BITS-1:0]  FORCE_INHIBITED = 16'hFFFF;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd150;
    localparam logic [COEFF_BITS-1:0]  COEFF_RESET  = 17'd13107;
    localparam logic                   AWAIT_RESET  = 1'b1;
    localparam logic                   PROX_RESET   = 1'b1;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_THRESH  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_COEFF   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_AWAIT   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_PROX    = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_INHIBIT = 3'd4;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_HIT    = 1'b1;

    typedef struct packed {
        logic                   gate;
        logic [THRESH_BITS-1:0] threshold;
    } phd_cfg_t;

endpackage

`default_nettype wire

[hdl/phd_lane.sv]
`default_nettype none

module phd_lane
    import phd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [COEFF_BITS-1:0]  coeff,
    output logic      [SAMPLE_BITS-1:0] level
);

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = COEFF_BITS + 1 + DIFF_BITS;
    localparam int STEP_BITS = PROD_BITS - Q_FRAC_BITS;

    logic signed [DIFF_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [STEP_BITS-1:0] step;
    logic [SAMPLE_BITS-1:0]      level_reg;
    logic [SAMPLE_BITS-1:0]      level_next;

    // level + floor(coeff * (sample - level) / 2^16)
    always_comb
    begin
        diff       = $signed({1'b0, sample}) - $signed({1'b0, level_reg});
        prod       = $signed({1'b0, coeff}) * diff;
        step       = prod[PROD_BITS-1:Q_FRAC_BITS];
        level_next = level_reg + step[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (en)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

[hdl/phd_merge.sv]
`default_nettype none

`include "piezo_hit_detector_unit_defines.svh"

module phd_merge
    import phd_pkg::*;
#(
    parameter  int NUM_PADS    = NUM_PADS_DEF,
    parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int PAD_BITS    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  load_valid,
    output logic                                       load_ready,
    input  wire logic [NUM_PADS-1:0][SAMPLE_BITS-1:0]  levels_in,
    input  wire phd_cfg_t                              cfg,
    input  wire logic [NUM_PADS-1:0]                   inhibit,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       out_kind,
    output logic      [NUM_PADS-1:0][SAMPLE_BITS-1:0]  out_levels,
    output logic      [PAD_BITS-1:0]                   out_pad,
    output logic      [FORCE_BITS-1:0]                 out_force,
    output logic                                       out_last
);

    localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    logic                                 buf_valid_reg, buf_valid_next;
    logic                                 rep_pending_reg, rep_pending_next;
    logic [NUM_PADS-1:0]                  hits_reg, hits_next;
    logic [NUM_PADS-1:0][SAMPLE_BITS-1:0] levels_reg;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_kind_reg;
    logic [NUM_PADS-1:0][SAMPLE_BITS-1:0] out_levels_reg;
    logic [PAD_BITS-1:0]                  out_pad_reg;
    logic [FORCE_BITS-1:0]                out_force_reg;
    logic                                 out_last_reg;

    logic                   out_free;
    logic                   emit;
    logic                   next_last;
    logic                   buf_done;
    logic                   load;
    logic [NUM_PADS-1:0]    new_hits;
    logic [NUM_PADS-1:0]    sel_mask;
    logic [NUM_PADS-1:0]    rem_hits;
    logic [PAD_BITS-1:0]    sel_idx;
    logic [SAMPLE_BITS-1:0] sel_level;
    logic                   sel_inh;

    // lowest pad still to report
    always_comb
    begin
        sel_mask  = '0;
        sel_idx   = '0;
        sel_level = '0;
        sel_inh   = 1'b0;
        for (int i = NUM_PADS - 1; i >= 0; i--)
        begin
            if (hits_reg[i])
            begin
                sel_mask    = '0;
                sel_mask[i] = 1'b1;
                sel_idx     = PAD_BITS'(i);
                sel_level   = levels_reg[i];
                sel_inh     = inhibit[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PADS; i++)
        begin
            new_hits[i] = cfg.gate &&
                (CMP_BITS'(levels_in[i]) > CMP_BITS'(cfg.threshold));
        end
    end

    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        emit       = buf_valid_reg && out_free;
        rem_hits   = hits_reg & ~sel_mask;
        next_last  = rep_pending_reg ? (hits_reg == '0) : (rem_hits == '0);
        buf_done   = emit && next_last;
        load_ready = !buf_valid_reg || buf_done;
        load       = load_valid && load_ready;

        buf_valid_next   = load ? 1'b1 : (buf_done ? 1'b0 : buf_valid_reg);
        rep_pending_next = load ? 1'b1 : (emit ? 1'b0 : rep_pending_reg);
        if (load)
        begin
            hits_next = new_hits;
        end
        else if (emit && !rep_pending_reg)
        begin
            hits_next = rem_hits;
        end
        else
        begin
            hits_next = hits_reg;
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg   <= 1'b0;
            rep_pending_reg <= 1'b0;
            hits_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            buf_valid_reg   <= buf_valid_next;
            rep_pending_reg <= rep_pending_next;
            hits_reg        <= hits_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            levels_reg <= levels_in;
        end
        if (emit)
        begin
            out_last_reg <= next_last;
            if (rep_pending_reg)
            begin
                out_kind_reg   <= KIND_REPORT;
                out_levels_reg <= levels_reg;
                out_pad_reg    <= '0;
                out_force_reg  <= '0;
            end
            else
            begin
                out_kind_reg   <= KIND_HIT;
                out_levels_reg <= '0;
                out_pad_reg    <= sel_idx;
                out_force_reg  <= sel_inh ? FORCE_INHIBITED : FORCE_BITS'(sel_level);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_levels = out_levels_reg;
    assign out_pad    = out_pad_reg;
    assign out_force  = out_force_reg;
    assign out_last   = out_last_reg;

    `PHD_ASSERT_NOW(a_hit_needs_pending, emit && !rep_pending_reg, hits_reg != '0, "no pad left")
    `PHD_ASSERT_NEXT(a_hit_kind, emit && !rep_pending_reg, out_kind_reg == KIND_HIT, "bad kind")
    `PHD_ASSERT_NEXT(a_done_frees_buf, buf_done && !load_valid, !buf_valid_reg, "buffer held")
    `PHD_ASSERT_NEXT(a_gate_closed, load && !cfg.gate, hits_reg == '0, "hits with gate closed")
    `PHD_ASSERT_NEXT(a_rep_last, emit && rep_pending_reg && !next_last, !out_last_reg, "last early")

endmodule

`default_nettype wire

[hdl/piezo_hit_detector_unit.sv]
// channel   direction  handshake          payload
// s_*       in         tvalid/tready      tdata: sample_pad0..sample_padN
// m_*       out        tvalid/tready      tdata: levels, hit_pad, hit_force; tuser: item_kind;
//                                         tlast: last_of_run
// apb       in         psel/penable       five config registers at 4*i
//
// an item is registered in the pad lanes and then loaded into the result buffer when
// that is free; results leave one per cycle through the output register while m_tready is high
// each item gives 1 + (pads above threshold while await and prox are set) results,
// so 1 to 1+NUM_PADS results per item, all through the single output register
// rst_n clears pad levels and loads register defaults; m_tready low holds the
// output item and s_tready drops once lane stage and result buffer are both full
`default_nettype none

module piezo_hit_detector_unit
    import phd_pkg::*;
#(
    parameter  int NUM_PADS      = NUM_PADS_DEF,
    parameter  int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    localparam int PAD_BITS      = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1,
    localparam int IN_RAW_BITS   = NUM_PADS * SAMPLE_BITS,
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8,
    localparam int OUT_RAW_BITS  = NUM_PADS * SAMPLE_BITS + PAD_BITS + FORCE_BITS,
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // sample_pad0, sample_pad1, ... from bit 0
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,

    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // level_pad0 .. level_padN, hit_pad, hit_force from bit 0
    output logic      [OUT_DATA_BITS-1:0] m_tdata,
    // item_kind
    output logic                          m_tuser,
    output logic                          m_tlast,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    logic [THRESH_BITS-1:0] thresh_reg;
    logic [COEFF_BITS-1:0]  coeff_reg;
    logic                   await_reg;
    logic                   prox_reg;
    logic [NUM_PADS-1:0]    inhibit_reg;

    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr;
    logic [COEFF_BITS-1:0]   coeff_sat;
    phd_cfg_t                merge_cfg;

    logic                                 in_accept;
    logic                                 s1_valid_reg, s1_valid_next;
    logic                                 buf_ready;
    logic [NUM_PADS-1:0][SAMPLE_BITS-1:0] lane_levels;

    logic                                 out_kind;
    logic [NUM_PADS-1:0][SAMPLE_BITS-1:0] out_levels;
    logic [PAD_BITS-1:0]                  out_pad;
    logic [FORCE_BITS-1:0]                out_force;
    logic [OUT_RAW_BITS-1:0]              out_raw;

    // config port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= THRESH_RESET;
            coeff_reg   <= COEFF_RESET;
            await_reg   <= AWAIT_RESET;
            prox_reg    <= PROX_RESET;
            inhibit_reg <= '0;
        end
        else if (wr)
        begin
            case (reg_idx)
                REG_THRESH:  thresh_reg  <= pwdata[THRESH_BITS-1:0];
                REG_COEFF:   coeff_reg   <= pwdata[COEFF_BITS-1:0];
                REG_AWAIT:   await_reg   <= pwdata[0];
                REG_PROX:    prox_reg    <= pwdata[0];
                REG_INHIBIT: inhibit_reg <= pwdata[NUM_PADS-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESH:  prdata = APB_DATA_BITS'(thresh_reg);
            REG_COEFF:   prdata = APB_DATA_BITS'(coeff_reg);
            REG_AWAIT:   prdata = APB_DATA_BITS'(await_reg);
            REG_PROX:    prdata = APB_DATA_BITS'(prox_reg);
            REG_INHIBIT: prdata = APB_DATA_BITS'(inhibit_reg);
            default:     prdata = '0;
        endcase
    end

    // weights above one follow the sample
    assign coeff_sat = (coeff_reg > Q_ONE) ? Q_ONE : coeff_reg;

    assign merge_cfg.gate      = await_reg && prox_reg;
    assign merge_cfg.threshold = thresh_reg;

    // lane stage
    assign s_tready  = !s1_valid_reg || buf_ready;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (buf_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    for (genvar p = 0; p < NUM_PADS; p++)
    begin : g_lane
        phd_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (in_accept),
            .sample (s_tdata[p*SAMPLE_BITS +: SAMPLE_BITS]),
            .coeff  (coeff_sat),
            .level  (lane_levels[p])
        );
    end

    phd_merge #(
        .NUM_PADS    (NUM_PADS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid_reg),
        .load_ready (buf_ready),
        .levels_in  (lane_levels),
        .cfg        (merge_cfg),
        .inhibit    (inhibit_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_levels (out_levels),
        .out_pad    (out_pad),
        .out_force  (out_force),
        .out_last   (m_tlast)
    );

    assign out_raw = {out_force, out_pad, out_levels};
    assign m_tdata = OUT_DATA_BITS'(out_raw);
    assign m_tuser = out_kind;

endmodule

`default_nettype wire
